// ----- hdl/fnat_pkg.sv -----
// Shared types and constants of the face normal crease-angle test.
// Used by fnat_face and face_normal_angle_test_top; depends on nothing.
package fnat_pkg;

  // Fraction bits of a unit normal (Q1.30)
  localparam int NORM_FRAC     = 30;
  // Bit steps of the square root and of each divider, and steps per stage
  localparam int ROOT_STEPS    = 32;
  localparam int DIV_STEPS     = 32;
  localparam int STEPS_PER_STG = 2;
  localparam int ROOT_STG      = ROOT_STEPS / STEPS_PER_STG;
  localparam int DIV_STG       = DIV_STEPS / STEPS_PER_STG;
  // Products, difference, OR scan, leading one, scale, squares, sum,
  // divider setup and sign stage, plus the root and divider stages
  localparam int FACE_LAT      = 9 + ROOT_STG + DIV_STG;
  // Dot product, sum, round, saturate and compare follow the face units
  localparam int TOP_LAT       = FACE_LAT + 4;

  localparam logic [30:0] COS_THR_RESET = 31'd1063004406;
  localparam logic [33:0] COS_ONE       = 34'd1 << NORM_FRAC;
  localparam logic [63:0] ROUND_HALF    = 64'd1 << (NORM_FRAC - 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_COS_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_PLANAR_MODE   = 2'd1;

  typedef struct packed {
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
  } face_in_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic               degen;
  } face_res_t;

endpackage

// ----- hdl/fnat_face.sv -----
// Pipelined unit normal of one face: cross product or 2D perpendicular,
// scale, square root and three dividers. Depends on fnat_pkg.
module fnat_face import fnat_pkg::*; (
  input  logic      clk,
  input  logic      planar,
  input  face_in_t  face,
  output face_res_t res
);

  // Stage 1: raw product terms (or point coordinates in 2D)
  logic signed [63:0] prod_nxt [6];
  logic signed [63:0] prod_r   [6];

  always_comb begin
    if (planar) begin
      prod_nxt[0] = 64'(face.v1_y);
      prod_nxt[1] = 64'(face.v2_y);
      prod_nxt[2] = 64'(face.v2_x);
      prod_nxt[3] = 64'(face.v1_x);
      prod_nxt[4] = '0;
      prod_nxt[5] = '0;
    end else begin
      prod_nxt[0] = face.v1_y * face.v2_z;
      prod_nxt[1] = face.v1_z * face.v2_y;
      prod_nxt[2] = face.v1_z * face.v2_x;
      prod_nxt[3] = face.v1_x * face.v2_z;
      prod_nxt[4] = face.v1_x * face.v2_y;
      prod_nxt[5] = face.v1_y * face.v2_x;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage 2: differences as sign and magnitude
  logic [64:0] dif [3];
  logic [63:0] mag_nxt [3];
  logic [63:0] mag_r   [3];
  logic [2:0]  neg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {prod_r[2*i][63], prod_r[2*i]} - {prod_r[2*i+1][63], prod_r[2*i+1]};
      mag_nxt[i] = dif[i][64] ? 64'(~dif[i] + 65'd1) : dif[i][63:0];
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    for (int i = 0; i < 3; i++) neg_r[i] <= dif[i][64];
  end

  // Stage 3: OR of the magnitudes and per-byte flags
  logic [63:0] or_r;
  logic [7:0]  grp_r;
  logic [63:0] mag3_r [3];
  logic [2:0]  neg3_r;
  logic [63:0] or_w;

  assign or_w = mag_r[0] | mag_r[1] | mag_r[2];

  always_ff @(posedge clk) begin
    or_r   <= or_w;
    for (int g = 0; g < 8; g++) grp_r[g] <= |or_w[8*g +: 8];
    mag3_r <= mag_r;
    neg3_r <= neg_r;
  end

  // Stage 4: bit length of the largest magnitude
  logic [2:0]  top_byte;
  logic [7:0]  top_bits;
  logic [2:0]  top_pos;
  logic [6:0]  len_nxt;
  logic [6:0]  len_r;
  logic [63:0] mag4_r [3];
  logic [2:0]  neg4_r;

  always_comb begin
    top_byte = '0;
    for (int g = 0; g < 8; g++) if (grp_r[g]) top_byte = 3'(g);
    top_bits = or_r[{top_byte, 3'b000} +: 8];
    top_pos  = '0;
    for (int b = 0; b < 8; b++) if (top_bits[b]) top_pos = 3'(b);
    len_nxt  = (|grp_r) ? ({1'b0, top_byte, top_pos} + 7'd1) : 7'd0;
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    mag4_r <= mag3_r;
    neg4_r <= neg3_r;
  end

  // Stage 5: scale so the largest component lies in [2^30, 2^31)
  logic [30:0] scl_nxt [3];
  logic [30:0] scl_r   [3];
  logic [2:0]  neg5_r;
  logic        zero5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len_r > 7'd31) scl_nxt[i] = 31'(mag4_r[i] >> (len_r - 7'd31));
      else               scl_nxt[i] = 31'(mag4_r[i] << (7'd31 - len_r));
    end
  end

  always_ff @(posedge clk) begin
    scl_r   <= scl_nxt;
    neg5_r  <= neg4_r;
    zero5_r <= (len_r == 7'd0);
  end

  // Stage 6: squares
  logic [61:0] sqr_r  [3];
  logic [30:0] scl6_r [3];
  logic [2:0]  neg6_r;
  logic        zero6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sqr_r[i] <= 62'(scl_r[i]) * 62'(scl_r[i]);
    scl6_r  <= scl_r;
    neg6_r  <= neg5_r;
    zero6_r <= zero5_r;
  end

  // Stage 7 and root stages: bit-by-bit floor square root of the sum
  logic [63:0] rx_r    [ROOT_STG+1];
  logic [35:0] rrem_r  [ROOT_STG+1];
  logic [31:0] rroot_r [ROOT_STG+1];
  logic [30:0] rscl_r  [ROOT_STG+1][3];
  logic [2:0]  rneg_r  [ROOT_STG+1];
  logic        rzero_r [ROOT_STG+1];

  always_ff @(posedge clk) begin
    rx_r[0]    <= 64'(sqr_r[0]) + 64'(sqr_r[1]) + 64'(sqr_r[2]);
    rrem_r[0]  <= '0;
    rroot_r[0] <= '0;
    rscl_r[0]  <= scl6_r;
    rneg_r[0]  <= neg6_r;
    rzero_r[0] <= zero6_r;
  end

  for (genvar k = 0; k < ROOT_STG; k++) begin : g_root
    logic [63:0] x;
    logic [35:0] r;
    logic [31:0] q;

    always_comb begin
      x = rx_r[k];
      r = rrem_r[k];
      q = rroot_r[k];
      for (int s = 0; s < STEPS_PER_STG; s++) begin
        r = {r[33:0], x[63:62]};
        x = {x[61:0], 2'b00};
        if (r >= {2'b00, q, 2'b01}) begin
          r = r - {2'b00, q, 2'b01};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rx_r[k+1]    <= x;
      rrem_r[k+1]  <= r;
      rroot_r[k+1] <= q;
      rscl_r[k+1]  <= rscl_r[k];
      rneg_r[k+1]  <= rneg_r[k];
      rzero_r[k+1] <= rzero_r[k];
    end
  end

  // Divider setup: numerator = scaled << 30 plus half the length
  logic [32:0] drem_r  [DIV_STG+1][3];
  logic [31:0] dnum_r  [DIV_STG+1][3];
  logic [31:0] dquo_r  [DIV_STG+1][3];
  logic [31:0] dlen_r  [DIV_STG+1];
  logic [2:0]  dneg_r  [DIV_STG+1];
  logic        dzero_r [DIV_STG+1];
  logic [61:0] num     [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = (62'(rscl_r[ROOT_STG][j]) << NORM_FRAC) + 62'(rroot_r[ROOT_STG] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      drem_r[0][j] <= 33'(num[j][61:32]);
      dnum_r[0][j] <= num[j][31:0];
      dquo_r[0][j] <= '0;
    end
    dlen_r[0]  <= rroot_r[ROOT_STG];
    dneg_r[0]  <= rneg_r[ROOT_STG];
    dzero_r[0] <= rzero_r[ROOT_STG];
  end

  // Restoring division, three lanes side by side
  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    logic [32:0] r [3];
    logic [31:0] n [3];
    logic [31:0] q [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        r[j] = drem_r[k][j];
        n[j] = dnum_r[k][j];
        q[j] = dquo_r[k][j];
        for (int s = 0; s < STEPS_PER_STG; s++) begin
          r[j] = {r[j][31:0], n[j][31]};
          n[j] = {n[j][30:0], 1'b0};
          if (r[j] >= {1'b0, dlen_r[k]}) begin
            r[j] = r[j] - {1'b0, dlen_r[k]};
            q[j] = {q[j][30:0], 1'b1};
          end else begin
            q[j] = {q[j][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      drem_r[k+1]  <= r;
      dnum_r[k+1]  <= n;
      dquo_r[k+1]  <= q;
      dlen_r[k+1]  <= dlen_r[k];
      dneg_r[k+1]  <= dneg_r[k];
      dzero_r[k+1] <= dzero_r[k];
    end
  end

  // Sign stage: apply signs, zero a degenerate normal
  logic signed [31:0] comp [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dzero_r[DIV_STG])     comp[j] = '0;
      else if (dneg_r[DIV_STG][j]) comp[j] = -$signed(dquo_r[DIV_STG][j]);
      else                      comp[j] = $signed(dquo_r[DIV_STG][j]);
    end
  end

  always_ff @(posedge clk) begin
    res.nx    <= comp[0];
    res.ny    <= comp[1];
    res.nz    <= comp[2];
    res.degen <= dzero_r[DIV_STG];
  end

endmodule

// ----- hdl/face_normal_angle_test_top.sv -----
// Top level of the face normal crease-angle test: config registers, two
// face normal pipelines, dot product and threshold. Depends on fnat_pkg, fnat_face.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   input   | start, busy (busy held 0)  | in_a_vec1_x .. in_b_vec2_z
//   result  | out_valid strobe, no stall | out_normal_a_x/y/z, out_abs_cosine,
//           |                            | out_similar, out_degenerate
//   config  | cfg_valid, cfg_ready (1)   | cfg_index, cfg_wdata
//
// One beat enters per cycle; its result leaves through the face units and the dot-product stages.
// The latency is set by the 16-stage square root and the 16-stage dividers,
// two bit steps per stage, behind seven stages of products and scaling.
// Reset clears the valid chain and loads the config registers with their reset values; no clearing pass.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
module face_normal_angle_test_top import fnat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_a_vec1_x,
  input  logic signed [31:0] in_a_vec1_y,
  input  logic signed [31:0] in_a_vec1_z,
  input  logic signed [31:0] in_a_vec2_x,
  input  logic signed [31:0] in_a_vec2_y,
  input  logic signed [31:0] in_a_vec2_z,
  input  logic signed [31:0] in_b_vec1_x,
  input  logic signed [31:0] in_b_vec1_y,
  input  logic signed [31:0] in_b_vec1_z,
  input  logic signed [31:0] in_b_vec2_x,
  input  logic signed [31:0] in_b_vec2_y,
  input  logic signed [31:0] in_b_vec2_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_normal_a_x,
  output logic signed [31:0] out_normal_a_y,
  output logic signed [31:0] out_normal_a_z,
  output logic [30:0]        out_abs_cosine,
  output logic               out_similar,
  output logic               out_degenerate
);

  // Fully pipelined: take a beat every cycle, take config at once
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = start && !busy;

  // Configuration registers
  logic [30:0] cos_thr_r;
  logic        planar_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_thr_r <= COS_THR_RESET;
      planar_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COS_THRESHOLD: cos_thr_r <= cfg_wdata[30:0];
        CFG_PLANAR_MODE:   planar_r  <= cfg_wdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Valid chain: one bit per stage, advanced every cycle
  logic [TOP_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[TOP_LAT-2:0], in_fire};
  end

  // Both faces go through identical pipelines, so their results line up
  face_in_t  face_a, face_b;
  face_res_t res_a, res_b;

  assign face_a = '{v1_x: in_a_vec1_x, v1_y: in_a_vec1_y, v1_z: in_a_vec1_z,
                    v2_x: in_a_vec2_x, v2_y: in_a_vec2_y, v2_z: in_a_vec2_z};
  assign face_b = '{v1_x: in_b_vec1_x, v1_y: in_b_vec1_y, v1_z: in_b_vec1_z,
                    v2_x: in_b_vec2_x, v2_y: in_b_vec2_y, v2_z: in_b_vec2_z};

  fnat_face u_face_a (
    .clk    (clk),
    .planar (planar_r),
    .face   (face_a),
    .res    (res_a)
  );

  fnat_face u_face_b (
    .clk    (clk),
    .planar (planar_r),
    .face   (face_b),
    .res    (res_b)
  );

  // D1: component products of the dot product
  logic signed [63:0] dprod_r [3];
  face_res_t          na_r    [3];
  logic               degen_r [3];

  always_ff @(posedge clk) begin
    dprod_r[0] <= res_a.nx * res_b.nx;
    dprod_r[1] <= res_a.ny * res_b.ny;
    dprod_r[2] <= res_a.nz * res_b.nz;
    na_r[0]    <= res_a;
    degen_r[0] <= res_a.degen || res_b.degen;
  end

  // D2: exact sum
  logic signed [63:0] dot_r;

  always_ff @(posedge clk) begin
    dot_r      <= dprod_r[0] + dprod_r[1] + dprod_r[2];
    na_r[1]    <= na_r[0];
    degen_r[1] <= degen_r[0];
  end

  // D3: magnitude, round half up to Q1.30
  logic [62:0] dot_abs;
  logic [33:0] rnd_r;

  assign dot_abs = dot_r[63] ? 63'(-dot_r) : 63'(dot_r);

  always_ff @(posedge clk) begin
    rnd_r      <= 34'((64'(dot_abs) + ROUND_HALF) >> NORM_FRAC);
    na_r[2]    <= na_r[1];
    degen_r[2] <= degen_r[1];
  end

  // D4: saturate at one, force zero on a degenerate face, compare
  logic [33:0] cos_sat;

  always_comb begin
    cos_sat = (rnd_r > COS_ONE) ? COS_ONE : rnd_r;
    if (degen_r[2]) cos_sat = '0;
  end

  always_ff @(posedge clk) begin
    out_normal_a_x <= na_r[2].nx;
    out_normal_a_y <= na_r[2].ny;
    out_normal_a_z <= na_r[2].nz;
    out_abs_cosine <= cos_sat[30:0];
    out_similar    <= !degen_r[2] && (cos_sat > {3'b000, cos_thr_r});
    out_degenerate <= degen_r[2];
  end

  assign out_valid = vld_r[TOP_LAT-1];

`ifndef SYNTHESIS
  a_cos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({3'b000, out_abs_cosine} <= COS_ONE))
    else $error("abs_cosine above one");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_abs_cosine == '0 && !out_similar))
    else $error("degenerate beat with nonzero cosine or similar set");

  a_similar_above: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_similar) |-> (out_abs_cosine > cos_thr_r))
    else $error("similar set at or below threshold");
`endif

endmodule

// ----- sim/tb.sv -----
// Testbench of face_normal_angle_test_top: drives face pairs and config writes,
// predicts each normal/cosine result and compares it. Depends on fnat_pkg and the RTL.
module tb;
  import fnat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] nx, ny, nz;
    logic [30:0]        cosv;
    logic               sim, deg;
  } crease_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] f_in [12];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [31:0] out_normal_a_x, out_normal_a_y, out_normal_a_z;
  logic [30:0] out_abs_cosine;
  logic out_similar, out_degenerate;

  // Shadow copy of the config registers
  logic [30:0] thr_shadow = COS_THR_RESET;
  logic        planar_shadow = 1'b0;

  crease_res_t pending_res[$];
  int  fails = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  initial for (int i = 0; i < 12; i++) f_in[i] = '0;

  face_normal_angle_test_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_vec1_x(f_in[0]), .in_a_vec1_y(f_in[1]), .in_a_vec1_z(f_in[2]),
    .in_a_vec2_x(f_in[3]), .in_a_vec2_y(f_in[4]), .in_a_vec2_z(f_in[5]),
    .in_b_vec1_x(f_in[6]), .in_b_vec1_y(f_in[7]), .in_b_vec1_z(f_in[8]),
    .in_b_vec2_x(f_in[9]), .in_b_vec2_y(f_in[10]), .in_b_vec2_z(f_in[11]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_normal_a_x(out_normal_a_x), .out_normal_a_y(out_normal_a_y),
    .out_normal_a_z(out_normal_a_z), .out_abs_cosine(out_abs_cosine),
    .out_similar(out_similar), .out_degenerate(out_degenerate));

  // Floor integer square root, bit by bit
  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Unit normal of one face; returns 0 when the raw normal is zero
  function automatic bit face_unit(input logic signed [31:0] v[6], input bit planar,
                                   output logic signed [63:0] u[3]);
    logic signed [65:0] raw[3];
    logic [65:0] mag[3];
    logic [65:0] m;
    logic [63:0] sum, len, q;
    int lb;
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (planar) begin
      raw[0] = 66'(v[1]) - 66'(v[4]);
      raw[1] = 66'(v[3]) - 66'(v[0]);
      raw[2] = 0;
    end else begin
      raw[0] = 66'(v[1]) * 66'(v[5]) - 66'(v[2]) * 66'(v[4]);
      raw[1] = 66'(v[2]) * 66'(v[3]) - 66'(v[0]) * 66'(v[5]);
      raw[2] = 66'(v[0]) * 66'(v[4]) - 66'(v[1]) * 66'(v[3]);
    end
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw[i] < 0 ? -raw[i] : raw[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 0;
    lb = 0;
    while (lb < 66 && (m >> lb) != 0) lb++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (lb > 31) mag[i] = mag[i] >> (lb - 31);
      else mag[i] = mag[i] << (31 - lb);
      sum = sum + mag[i][63:0] * mag[i][63:0];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i][63:0] << NORM_FRAC) + (len >> 1)) / len;
      u[i] = raw[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic crease_res_t predict_crease(logic signed [31:0] v[12]);
    crease_res_t r;
    logic signed [31:0] fa[6], fb[6];
    logic signed [63:0] na[3], nb[3];
    logic signed [63:0] dot;
    logic [63:0] ad, c;
    bit oka, okb, dg;
    for (int i = 0; i < 6; i++) begin
      fa[i] = v[i];
      fb[i] = v[i + 6];
    end
    oka = face_unit(fa, planar_shadow, na);
    okb = face_unit(fb, planar_shadow, nb);
    dg = !(oka && okb);
    dot = na[0] * nb[0] + na[1] * nb[1] + na[2] * nb[2];
    ad = dot < 0 ? -dot : dot;
    c = (ad + ROUND_HALF) >> NORM_FRAC;
    if (c > 64'(COS_ONE)) c = 64'(COS_ONE);
    if (dg) c = 0;
    r.nx = na[0][31:0];
    r.ny = na[1][31:0];
    r.nz = na[2][31:0];
    r.cosv = c[30:0];
    r.sim = !dg && (c > 64'(thr_shadow));
    r.deg = dg;
    return r;
  endfunction

  // Checker: every strobe is one result beat, compared with the oldest prediction
  always @(posedge clk) begin
    crease_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result beat nx=%0d cos=%0d", $time, out_normal_a_x,
                 out_abs_cosine);
        fails++;
      end else begin
        e = pending_res.pop_front();
        if (out_normal_a_x !== e.nx || out_normal_a_y !== e.ny ||
            out_normal_a_z !== e.nz || out_abs_cosine !== e.cosv ||
            out_similar !== e.sim || out_degenerate !== e.deg) begin
          $display("%0t: mismatch expected n=(%0d,%0d,%0d) cos=%0d sim=%0b deg=%0b",
                   $time, e.nx, e.ny, e.nz, e.cosv, e.sim, e.deg);
          $display("%0t:          actual n=(%0d,%0d,%0d) cos=%0d sim=%0b deg=%0b",
                   $time, out_normal_a_x, out_normal_a_y, out_normal_a_z,
                   out_abs_cosine, out_similar, out_degenerate);
          fails++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run
  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, often none
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3));
    repeat (n) @(negedge clk);
  endtask

  // Send one beat; predict at acceptance. Start is driven at the falling edge,
  // so a beat that follows at once may drop and raise it in the same step.
  task automatic send_faces(logic signed [31:0] v[12], bit gaps = 1);
    if (gaps) idle_gap();
    f_in = v;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_res.push_back(predict_crease(v));
    @(negedge clk);
    start = 1'b0;
  endtask

  // Write one register while the pipeline is drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait (pending_res.size() == 0);
    @(negedge clk);
    repeat (TOP_LAT + 4) @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COS_THRESHOLD) thr_shadow = val[30:0];
    else if (idx == CFG_PLANAR_MODE) planar_shadow = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255) - 128;
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7fff_ffff - $urandom_range(0, 3);
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] v[12];
    // Unit axes: A normal +z, B normal +z -> similar
    v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_faces(v);
    // B perpendicular to A
    v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_faces(v);
    // Degenerate A (parallel edges), then degenerate B, then all zero
    v = '{5, 5, 5, 10, 10, 10, 1, 0, 0, 0, 1, 0};
    send_faces(v);
    v = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 7, 8, 9};
    send_faces(v);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_faces(v);
    // Extremes of every field
    for (int i = 0; i < 12; i++) v[i] = 32'sh8000_0000;
    send_faces(v);
    for (int i = 0; i < 12; i++) v[i] = 32'sh7fff_ffff;
    send_faces(v);
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000};
    send_faces(v);
    v = '{32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 0, 1, 0, 0, 0, -1, 1};
    send_faces(v);
    // Anti-parallel normals: abs cosine saturates at one
    v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
    send_faces(v, 0);
  endtask

  task automatic test_random(int n);
    logic signed [31:0] v[12];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 12; i++) v[i] = rand_coord();
      // Sometimes make B a scaled copy of A for near-one cosines
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 6; i++) v[i + 6] = v[i] >>> $urandom_range(0, 8);
      send_faces(v);
    end
  endtask

  task automatic test_planar();
    logic signed [31:0] v[12];
    write_reg(CFG_PLANAR_MODE, 32'd1);
    v = '{0, 0, 5, 32'h10000, 0, 9, 0, 0, -3, 0, 32'h10000, 7};
    send_faces(v);
    v = '{3, 4, 0, 3, 4, 0, 0, 0, 0, 1, 1, 0};
    send_faces(v);
    v = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0,
          0, 0, 0, 1, -1, 0};
    send_faces(v);
    test_random(200);
    write_reg(CFG_PLANAR_MODE, 32'hffff_fffe);
  endtask

  task automatic test_thresholds();
    write_reg(CFG_COS_THRESHOLD, 32'd0);
    test_random(150);
    write_reg(CFG_COS_THRESHOLD, 32'd1 << NORM_FRAC);
    test_random(100);
    write_reg(CFG_COS_THRESHOLD, 32'hffff_ffff);
    test_random(100);
    write_reg(CFG_COS_THRESHOLD, $urandom_range(0, 32'h4000_0000));
    write_reg(CFG_PLANAR_MODE, 32'd1);
    test_random(100);
    // Index beyond the list must be ignored
    write_reg(2'd3, 32'h0);
    write_reg(CFG_PLANAR_MODE, 32'd0);
    write_reg(CFG_COS_THRESHOLD, 32'h3fff_ffff);
    test_random(100);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_planar();
    test_thresholds();
    wait (pending_res.size() == 0);
    repeat (TOP_LAT + 10) @(negedge clk);
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/fnat_pkg.sv
hdl/fnat_face.sv
hdl/face_normal_angle_test_top.sv
sim/tb.sv
